@@ rtl/assert_macros.svh @@
// Assertion macros shared by the transform RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CRPT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CRPT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CRPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CRPT_ASSERT(label, clk, rst, prop, msg)
`define CRPT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define CRPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/crpt_pkg.sv @@
// Types and constants of the compound rigid pixel transform.
// No dependencies; every RTL module of the block imports it.
package crpt_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    MODE_CMD   = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  // Motion command keys.
  typedef enum logic [2:0] {
    KEY_CW  = 3'd0,
    KEY_MX  = 3'd1,
    KEY_W   = 3'd2,
    KEY_A   = 3'd3,
    KEY_D   = 3'd4,
    KEY_S   = 3'd5,
    KEY_MY  = 3'd6,
    KEY_CCW = 3'd7
  } cmd_key_t;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Reset value of image width and height.
  localparam logic [14:0] DIM_RESET = 15'd512;

  // Move directions in the upright frame, clockwise from up.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Rotation codes, quarter turns clockwise.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Geometry derived from the configuration registers.
  typedef struct packed {
    logic [15:0] hm1;   // height - 1, wrapped
    logic [15:0] wm1;   // width - 1, wrapped
    logic [15:0] span;  // 2 * (width / 2) - 1, the rotation reflection term
  } geom_t;

  // Accumulated transform. Only the low 16 bits of a shift reach a pixel.
  typedef struct packed {
    logic [1:0]  rot;
    logic        flip_x;
    logic        flip_y;
    logic [15:0] shift_x;
    logic [15:0] shift_y;
  } xform_t;

endpackage

@@ rtl/crpt_cfg.sv @@
// Configuration registers: keeps the geometry terms derived from width and height.
// Depends on crpt_pkg.
module crpt_cfg
  import crpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [14:0] wr_data,
  output geom_t       geom
);

  localparam logic [15:0] DimM1Reset = {1'b0, DIM_RESET} - 16'd1;
  localparam logic [15:0] SpanReset  = {1'b0, DIM_RESET[14:1], 1'b0} - 16'd1;

  // The derived terms are computed once at write time.
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.hm1  <= DimM1Reset;
      geom.wm1  <= DimM1Reset;
      geom.span <= SpanReset;
    end else if (wr_en) begin
      case (wr_index)
        CFG_WIDTH: begin
          geom.wm1  <= {1'b0, wr_data} - 16'd1;
          geom.span <= {1'b0, wr_data[14:1], 1'b0} - 16'd1;
        end
        CFG_HEIGHT: begin
          geom.hm1 <= {1'b0, wr_data} - 16'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/crpt_xform.sv @@
// Accumulated transform state and its update by motion and clear requests.
// Depends on crpt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module crpt_xform
  import crpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_en,
  input  logic        clr_en,
  input  cmd_key_t    key,
  input  logic [15:0] amount,
  output xform_t      xf
);

  xform_t      xf_next;
  logic [1:0]  dir;
  logic [1:0]  eff;
  logic        on_y;
  logic        neg;
  logic        nonzero;
  logic [15:0] delta;

  // A negative amount on a rotation or move key is the same as the opposite key
  // with the magnitude, so the raw amount is used throughout modulo 2^16.
  always_comb begin
    case (key)
      KEY_W:   dir = DIR_UP;
      KEY_D:   dir = DIR_RIGHT;
      KEY_S:   dir = DIR_DOWN;
      default: dir = DIR_LEFT;
    endcase
    eff   = dir - xf.rot;
    on_y  = ~eff[0];
    neg   = eff[1] ^ (on_y ? xf.flip_x : xf.flip_y);
    delta = neg ? (16'd0 - amount) : amount;
  end

  assign nonzero = (amount != 16'd0);

  // Next transform for the request in hand.
  always_comb begin
    xf_next = xf;
    if (clr_en) begin
      xf_next = '0;
    end else if (cmd_en && nonzero) begin
      case (key)
        KEY_CW:  xf_next.rot = xf.rot + amount[1:0];
        KEY_CCW: xf_next.rot = xf.rot - amount[1:0];
        KEY_MX: begin
          if (xf.rot[0]) xf_next.flip_y = ~xf.flip_y;
          else           xf_next.flip_x = ~xf.flip_x;
        end
        KEY_MY: begin
          if (xf.rot[0]) xf_next.flip_x = ~xf.flip_x;
          else           xf_next.flip_y = ~xf.flip_y;
        end
        default: begin
          if (on_y) xf_next.shift_y = xf.shift_y + delta;
          else      xf_next.shift_x = xf.shift_x + delta;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xf <= '0;
    end else begin
      xf <= xf_next;
    end
  end

  `CRPT_ASSERT_NEXT(a_clear_upright, clk, rst, clr_en, xf == '0, "clear did not restore upright")
  `CRPT_ASSERT_NEXT(a_zero_amount_noop, clk, rst, cmd_en && !clr_en && amount == 16'd0, xf == $past(xf), "zero amount changed the transform")
  `CRPT_ASSERT_NEXT(a_mirror_toggles, clk, rst, cmd_en && !clr_en && nonzero && (key == KEY_MX || key == KEY_MY), (xf.flip_x ^ xf.flip_y) != ($past(xf.flip_x) ^ $past(xf.flip_y)), "mirror request did not toggle one flip")

endmodule

@@ rtl/crpt_pixmap.sv @@
// Pixel mapping: translate, mirror and rotate one pixel through the transform.
// Depends on crpt_pkg.
module crpt_pixmap
  import crpt_pkg::*;
(
  input  geom_t              geom,
  input  xform_t             xf,
  input  logic signed [15:0] pixel_row,
  input  logic signed [15:0] pixel_col,
  output logic signed [15:0] new_row,
  output logic signed [15:0] new_col
);

  logic [15:0] x1;
  logic [15:0] y1;
  logic [15:0] x2;
  logic [15:0] y2;
  logic [15:0] x3;
  logic [15:0] y3;

  // Row to y, then translate and mirror; all sums wrap at 16 bits.
  always_comb begin
    x1 = pixel_col + xf.shift_x;
    y1 = geom.hm1 - pixel_row + xf.shift_y;
    x2 = xf.flip_y ? (geom.wm1 - x1) : x1;
    y2 = xf.flip_x ? (geom.hm1 - y1) : y1;
  end

  // Rotation about (w/2, w/2): the offsets cancel, leaving a swap and a
  // reflection against span = 2 * (w/2) - 1.
  always_comb begin
    case (xf.rot)
      ROT_90: begin
        x3 = y2;
        y3 = geom.span - x2;
      end
      ROT_180: begin
        x3 = geom.span - x2;
        y3 = geom.span - y2;
      end
      ROT_270: begin
        x3 = geom.span - y2;
        y3 = x2;
      end
      default: begin
        x3 = x2;
        y3 = y2;
      end
    endcase
  end

  assign new_row = geom.hm1 - y3;
  assign new_col = x3;

endmodule

@@ rtl/compound_rigid_pixel_transform.sv @@
// Top level of the compound rigid pixel transform: stream ports, input and result registers.
// Depends on crpt_pkg, crpt_cfg, crpt_xform, crpt_pixmap and assert_macros.svh.
`include "assert_macros.svh"
// The block takes one request per clock unless a pixel waits for a full result
// register, and holds one accumulated transform. Each request passes an input
// register and, for a pixel, then a result register, so a pixel request waits in
// the input register while the result register is full, and a stream of pixels
// runs at one per cycle while the result stream is not stalled; motion and clear
// requests give no result and take effect for the very next request. Input tuser
// selects the kind: 0 motion command, 1 pixel, 2 clear, 3 ignored. Configuration
// writes are always taken and must be issued only while the block is idle.
module compound_rigid_pixel_transform
  import crpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: command_key[2:0], amount[18:3], pixel_row[34:19], pixel_col[50:35], zero[55:51]
  input  logic [55:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: new_row[15:0], new_col[31:16]
  output logic [31:0] m_axis_tdata
);

  geom_t              geom;
  xform_t             xf;
  logic               in_valid;
  mode_t              in_mode;
  cmd_key_t           in_key;
  logic [15:0]        in_amount;
  logic signed [15:0] in_row;
  logic signed [15:0] in_col;
  logic               out_free;
  logic               in_fire;
  logic               in_is_pixel;
  logic signed [15:0] map_row;
  logic signed [15:0] map_col;
  logic               out_valid;
  logic [31:0]        out_data;

  assign cfg_ready = 1'b1;

  crpt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .geom     (geom)
  );

  // Handshake: a held request leaves when it needs no result slot or one is free.
  assign in_is_pixel   = (in_mode == MODE_PIXEL);
  assign out_free      = ~out_valid | m_axis_tready;
  assign in_fire       = in_valid & (~in_is_pixel | out_free);
  assign s_axis_tready = ~in_valid | in_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode   <= mode_t'(s_axis_tuser);
      in_key    <= cmd_key_t'(s_axis_tdata[2:0]);
      in_amount <= s_axis_tdata[18:3];
      in_row    <= s_axis_tdata[34:19];
      in_col    <= s_axis_tdata[50:35];
    end
  end

  crpt_xform u_xform (
    .clk    (clk),
    .rst    (rst),
    .cmd_en (in_fire && in_mode == MODE_CMD),
    .clr_en (in_fire && in_mode == MODE_CLEAR),
    .key    (in_key),
    .amount (in_amount),
    .xf     (xf)
  );

  crpt_pixmap u_pixmap (
    .geom      (geom),
    .xf        (xf),
    .pixel_row (in_row),
    .pixel_col (in_col),
    .new_row   (map_row),
    .new_col   (map_col)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_is_pixel) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_is_pixel) begin
      out_data <= {map_col, map_row};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `CRPT_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !in_valid, s_axis_tready, "input register empty but request refused")
  `CRPT_ASSERT_IMPLY(a_result_from_pixel, clk, rst, $rose(out_valid), $past(in_valid) && $past(in_mode) == MODE_PIXEL, "result without a pixel request")
  `CRPT_ASSERT_NEXT(a_pixel_held_on_stall, clk, rst, in_valid && in_is_pixel && out_valid && !m_axis_tready, in_valid && in_is_pixel && $stable(in_row) && $stable(in_col), "stalled pixel request was lost")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of compound_rigid_pixel_transform: directed and random requests
// under several image geometries, checked against a predictor of the accumulated transform.
// Depends on crpt_pkg and the block's RTL only.
module tb
  import crpt_pkg::*;
();

  // Request kind that the block must drop without a result.
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  // Cycles to let a result-less request leave the pipeline before reconfiguring.
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEMS_PER_GEOMETRY = 50;

  typedef struct {
    logic [1:0]  mode;
    cmd_key_t    key;
    logic [15:0] amount;
    logic [15:0] row;
    logic [15:0] col;
  } request_t;

  typedef struct {
    logic [15:0] row;
    logic [15:0] col;
  } pixel_t;

  typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [14:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  // Predicted transform state and geometry.
  logic [1:0]  rot = ROT_0;
  logic        mirror_x = 1'b0;
  logic        mirror_y = 1'b0;
  logic [31:0] offset_x = '0;
  logic [31:0] offset_y = '0;
  logic [14:0] img_width = DIM_RESET;
  logic [14:0] img_height = DIM_RESET;

  pixel_t expected_pixels[$];

  int error_count = 0;
  int results_checked = 0;
  int pixel_count = 0;
  int command_count = 0;
  int clear_count = 0;
  int ignored_count = 0;
  int geometry_count = 0;
  int burst_left = 0;
  int stall_left = 0;
  ready_style_t stall_style = READY_ALWAYS;

  compound_rigid_pixel_transform i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= 25) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Moves a pixel through the current transform, all arithmetic wrapped to 16 bits.
  function automatic pixel_t transform_pixel(logic [15:0] row, logic [15:0] col);
    logic [15:0] hm1, wm1, centre, x, y, t;
    pixel_t p;
    hm1 = {1'b0, img_height} - 16'd1;
    wm1 = {1'b0, img_width} - 16'd1;
    centre = {2'b00, img_width[14:1]};
    x = col + offset_x[15:0];
    y = hm1 - row + offset_y[15:0];
    if (mirror_x) y = hm1 - y;
    if (mirror_y) x = wm1 - x;
    // Rotate about (centre, centre); -v-1 is the bitwise inverse.
    if (rot != ROT_0) begin
      x = x - centre;
      y = y - centre;
      case (rot)
        ROT_90: begin
          t = x;
          x = y;
          y = ~t;
        end
        ROT_180: begin
          x = ~x;
          y = ~y;
        end
        default: begin
          t = x;
          x = ~y;
          y = t;
        end
      endcase
      x = x + centre;
      y = y + centre;
    end
    p.row = hm1 - y;
    p.col = x;
    return p;
  endfunction

  // Updates the predicted transform for one motion command.
  task automatic apply_motion(cmd_key_t key, logic [15:0] amount);
    logic [31:0] steps;
    logic [1:0]  dir, facing;
    logic        neg;
    if (amount != 16'd0) begin
      steps = {16'd0, amount};
      // A negative amount on a turn or move key becomes the opposite key.
      if (amount[15] && key != KEY_MX && key != KEY_MY) begin
        key = cmd_key_t'(~key);
        steps = 32'h10000 - steps;
      end
      case (key)
        KEY_CW:  rot = rot + steps[1:0];
        KEY_CCW: rot = rot - steps[1:0];
        KEY_MX: begin
          if (rot[0]) mirror_y = ~mirror_y;
          else mirror_x = ~mirror_x;
        end
        KEY_MY: begin
          if (rot[0]) mirror_x = ~mirror_x;
          else mirror_y = ~mirror_y;
        end
        default: begin
          case (key)
            KEY_W:   dir = DIR_UP;
            KEY_D:   dir = DIR_RIGHT;
            KEY_S:   dir = DIR_DOWN;
            default: dir = DIR_LEFT;
          endcase
          // Direction as seen in the rotated frame decides axis and sign.
          facing = dir - rot;
          neg = facing[1];
          if (!facing[0]) begin
            neg = neg ^ mirror_x;
            offset_y = neg ? offset_y - steps : offset_y + steps;
          end else begin
            neg = neg ^ mirror_y;
            offset_x = neg ? offset_x - steps : offset_x + steps;
          end
        end
      endcase
    end
  endtask

  // Applies one accepted request to the predicted state.
  task automatic predict_request(request_t r);
    case (r.mode)
      MODE_CMD: begin
        command_count++;
        apply_motion(r.key, r.amount);
      end
      MODE_PIXEL: begin
        pixel_count++;
        expected_pixels.push_back(transform_pixel(r.row, r.col));
      end
      MODE_CLEAR: begin
        clear_count++;
        rot = ROT_0;
        mirror_x = 1'b0;
        mirror_y = 1'b0;
        offset_x = '0;
        offset_y = '0;
      end
      default: ignored_count++;
    endcase
  endtask

  // Sends one request, opening a random gap whenever the current burst is used up.
  task automatic send_request(request_t r);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= r.mode;
    s_tdata <= {5'd0, r.col, r.row, r.amount, r.key};
    do @(posedge clk); while (!s_tready);
    predict_request(r);
  endtask

  // Stops sending and waits until every result has come and the pipeline is empty.
  task automatic await_drain();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic index, logic [14:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == CFG_WIDTH) img_width = value;
    else img_height = value;
  endtask

  // Writes both geometry registers back to back; the block must be idle.
  task automatic set_geometry(logic [14:0] width, logic [14:0] height);
    write_register(CFG_WIDTH, width);
    write_register(CFG_HEIGHT, height);
    cfg_valid <= 1'b0;
    geometry_count++;
  endtask

  // Requests with the fields the kind ignores filled at random.
  function automatic request_t command_request(cmd_key_t key, logic [15:0] amount);
    request_t r;
    r.mode = MODE_CMD;
    r.key = key;
    r.amount = amount;
    r.row = 16'($urandom);
    r.col = 16'($urandom);
    return r;
  endfunction

  function automatic request_t pixel_request(logic [15:0] row, logic [15:0] col);
    request_t r;
    r = command_request(cmd_key_t'($urandom_range(0, 7)), 16'($urandom));
    r.mode = MODE_PIXEL;
    r.row = row;
    r.col = col;
    return r;
  endfunction

  function automatic request_t control_request(logic [1:0] mode);
    request_t r;
    r = pixel_request(16'($urandom), 16'($urandom));
    r.mode = mode;
    return r;
  endfunction

  function automatic logic [15:0] random_amount();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'd0;
      3, 4, 5, 6: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_coord(logic [14:0] limit);
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, limit));
    return 16'($urandom);
  endfunction

  // Every key, zero and negative amounts, extreme coordinates, clear and the dropped kind.
  task automatic test_directed_commands();
    request_t plan[$];
    plan.push_back(pixel_request(16'd0, 16'd0));
    plan.push_back(pixel_request(16'h8000, 16'h7FFF));
    plan.push_back(pixel_request(16'h7FFF, 16'h8000));
    plan.push_back(control_request(MODE_IGNORED));
    plan.push_back(command_request(KEY_W, 16'd5));
    plan.push_back(command_request(KEY_D, -16'sd3));
    plan.push_back(command_request(KEY_CW, 16'd1));
    plan.push_back(pixel_request(16'd10, 16'd20));
    plan.push_back(command_request(KEY_MX, -16'sd7));
    plan.push_back(command_request(KEY_S, 16'd0));
    plan.push_back(command_request(KEY_A, 16'h8000));
    plan.push_back(pixel_request(16'hFFFF, 16'hFFFF));
    plan.push_back(command_request(KEY_MY, 16'd2));
    plan.push_back(command_request(KEY_CCW, -16'sd1));
    plan.push_back(pixel_request(16'd100, 16'd200));
    plan.push_back(command_request(KEY_CW, 16'd2));
    plan.push_back(command_request(KEY_CCW, 16'h7FFF));
    plan.push_back(command_request(KEY_MX, 16'd1));
    plan.push_back(pixel_request(16'h7FFF, 16'h7FFF));
    plan.push_back(command_request(KEY_W, 16'h7FFF));
    plan.push_back(pixel_request(16'h8000, 16'h8000));
    plan.push_back(control_request(MODE_CLEAR));
    plan.push_back(pixel_request(16'd7, 16'd9));
    plan.push_back(command_request(KEY_CW, 16'd3));
    plan.push_back(pixel_request(16'd0, 16'd0));
    foreach (plan[i]) send_request(plan[i]);
    await_drain();
  endtask

  // Random mix of motion, pixel, clear and dropped requests under one geometry.
  task automatic test_random_transforms(logic [14:0] width, logic [14:0] height);
    request_t r;
    int pick;
    set_geometry(width, height);
    for (int i = 0; i < ITEMS_PER_GEOMETRY; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) r = command_request(cmd_key_t'($urandom_range(0, 7)), random_amount());
      else if (pick < 88) r = pixel_request(random_coord(height), random_coord(width));
      else if (pick < 94) r = control_request(MODE_CLEAR);
      else r = control_request(MODE_IGNORED);
      send_request(r);
    end
    await_drain();
  endtask

  // Result side: drives m_tready in a stall pattern that it picks anew at random.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= ready_style_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:      m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compares each accepted result with the oldest predicted pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result %h with no pixel pending", m_tdata));
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (m_tdata[15:0] !== want.row)
          report_mismatch($sformatf("new_row %h, predicted %h", m_tdata[15:0], want.row));
        if (m_tdata[31:16] !== want.col)
          report_mismatch($sformatf("new_col %h, predicted %h", m_tdata[31:16], want.col));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_random_transforms(DIM_RESET, DIM_RESET);
    test_random_transforms(15'd1, 15'd1);
    test_random_transforms(15'd32767, 15'd32767);
    test_random_transforms(15'd1, 15'd32767);
    test_random_transforms(15'd32767, 15'd1);
    test_random_transforms(15'd0, 15'd0);
    test_random_transforms(15'($urandom_range(1, 1024)), 15'($urandom_range(1, 1024)));
    test_random_transforms(15'($urandom), 15'($urandom));
    $display("Sent %0d pixels, %0d motion commands, %0d clears, %0d dropped requests;",
             pixel_count, command_count, clear_count, ignored_count);
    $display("%0d geometries, %0d results compared, %0d mismatches.",
             geometry_count, results_checked, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
